### rtl/core/fvlra_pkg.sv
package fvlra_pkg;

  // Link action codes.
  localparam logic ACT_INTERIOR = 1'b0;
  localparam logic ACT_BOUNDARY = 1'b1;

  // Boundary kinds.
  localparam logic [1:0] BND_FIXED    = 2'd0;
  localparam logic [1:0] BND_GRADIENT = 2'd1;
  localparam logic [1:0] BND_SYMMETRY = 2'd2;
  localparam logic [1:0] BND_UNKNOWN  = 2'd3;

  // Result entry kinds.
  localparam logic [1:0] ENT_OFFDIAG = 2'd0;
  localparam logic [1:0] ENT_RHS     = 2'd1;
  localparam logic [1:0] ENT_DIAG    = 2'd2;
  localparam logic [1:0] ENT_ERROR   = 2'd3;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  localparam logic [47:0] SUM_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SUM_MIN = 48'h8000_0000_0000;

  // Multiply schedule length: six issues, the last product lands in the following cycle.
  localparam logic [4:0] MUL_LAST = 5'd6;
  localparam logic [4:0] DIV_LAST = 5'd31;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_QSAT,
    ST_APPLY,
    ST_RHS_MUL,
    ST_RHS_SAT,
    ST_RES,
    ST_DIAG
  } state_e;

  // Signed value from sign and magnitude, saturated to 32 bits.
  function automatic logic [31:0] sat_mag(input logic neg, input logic [47:0] mag);
    logic [31:0] res;
    if (neg) begin
      res = (mag >= 48'h0000_8000_0000) ? Q_MIN : (32'd0 - mag[31:0]);
    end else begin
      res = (mag >= 48'h0000_7FFF_FFFF) ? Q_MAX : mag[31:0];
    end
    return res;
  endfunction

  // 48-bit accumulator saturated to 32 bits.
  function automatic logic [31:0] sat_sum(input logic [47:0] v);
    logic [31:0] res;
    if (!v[47] && (v[46:31] != 16'h0000)) begin
      res = Q_MAX;
    end else if (v[47] && (v[46:31] != 16'hFFFF)) begin
      res = Q_MIN;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

### rtl/core/fv_laplacian_row_assembler.sv
// Finite-volume Laplacian row assembler. Takes one face link per input beat and computes
// coeff = gamma * dot(r,n) / dot(r,r) in Q16.16, emitting off-diagonal entries, fixed-value
// right-hand-side updates, error beats and the diagonal entry on a cell's last link. An
// interior or fixed-value boundary link uses one shared 33x33 multiplier for the two dot
// products and the 95-bit numerator, then a range check, a radix-2 restoring divider for the
// 32-bit quotient and, for a fixed-value link, a further multiplier pass for a right-hand-side
// product. A coefficient that the range check already saturates skips the divider. Error
// links go straight to the result, and normal-gradient or symmetry links add only the diagonal
// entry on a cell's last link. The input is not ready while a link is being worked, but a
// finished result waits in the output register without blocking the next beat.
module fv_laplacian_row_assembler #(
  parameter int unsigned MAX_CELLS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [15:0] row_index_i,
  input  logic [15:0] neighbour_index_i,
  input  logic [31:0] dist_x_i,
  input  logic [31:0] dist_y_i,
  input  logic [31:0] norm_x_i,
  input  logic [31:0] norm_y_i,
  input  logic [30:0] face_gamma_i,
  input  logic [1:0]  boundary_kind_i,
  input  logic [31:0] boundary_value_i,
  input  logic        last_link_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  entry_kind_o,
  output logic [15:0] out_row_o,
  output logic [15:0] out_col_o,
  output logic [31:0] out_value_o,
  output logic        last_of_run_o
);

  fvlra_pkg::state_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [47:0] sum_q, sum_d;
  logic        out_valid_q, out_valid_d;

  // Latched link.
  logic        action_q;
  logic [15:0] row_q, col_q;
  logic [31:0] rx_q, ry_q, nx_q, ny_q, bval_q;
  logic [30:0] gamma_q;
  logic        last_q;

  // Datapath registers.
  logic signed [65:0] prod_q;
  logic [65:0] acc_q, acc_d;
  logic [63:0] dn_q, dn_d;
  logic        neg_q, neg_d;
  logic [63:0] dd_q, dd_d;
  logic [63:0] t_q, t_d;
  logic [95:0] num_q, num_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] lo_q, lo_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] coeff_q, coeff_d;
  logic [1:0]  res_kind_q, res_kind_d;
  logic [15:0] res_col_q, res_col_d;
  logic [31:0] res_val_q, res_val_d;

  logic [1:0]  out_kind_q, out_kind_d;
  logic [15:0] out_row_q, out_row_d;
  logic [15:0] out_col_q, out_col_d;
  logic [31:0] out_val_q, out_val_d;
  logic        out_last_q, out_last_d;

  logic signed [32:0] mul_a, mul_b;
  logic        in_acc, out_free;
  logic        bad_idx;
  logic [65:0] dot_sum;
  logic [63:0] u_sum;
  logic [64:0] rem_sh;
  logic        geq;
  logic [31:0] cmag, vmag;
  logic [48:0] sub_res;

  assign in_ready_o = (state_q == fvlra_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign bad_idx    = ({16'b0, row_index_i} >= 32'(MAX_CELLS)) ||
                      ((action_i == fvlra_pkg::ACT_INTERIOR) &&
                       ({16'b0, neighbour_index_i} >= 32'(MAX_CELLS)));

  assign cmag = coeff_q[31] ? (32'd0 - coeff_q) : coeff_q;
  assign vmag = bval_q[31] ? (32'd0 - bval_q) : bval_q;

  // Shared multiplier operand select.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == fvlra_pkg::ST_MUL) begin
      case (cnt_q)
        5'd0: begin
          mul_a = {rx_q[31], rx_q};
          mul_b = {nx_q[31], nx_q};
        end
        5'd1: begin
          mul_a = {ry_q[31], ry_q};
          mul_b = {ny_q[31], ny_q};
        end
        5'd2: begin
          mul_a = {rx_q[31], rx_q};
          mul_b = {rx_q[31], rx_q};
        end
        5'd3: begin
          mul_a = {ry_q[31], ry_q};
          mul_b = {ry_q[31], ry_q};
        end
        5'd4: begin
          mul_a = {2'b00, gamma_q};
          mul_b = {1'b0, dn_q[31:0]};
        end
        default: begin
          mul_a = {2'b00, gamma_q};
          mul_b = {1'b0, dn_q[63:32]};
        end
      endcase
    end else if (state_q == fvlra_pkg::ST_RHS_MUL) begin
      mul_a = {1'b0, cmag};
      mul_b = {1'b0, vmag};
    end
  end

  assign dot_sum = acc_q + prod_q;
  assign u_sum   = prod_q[63:0] + {32'b0, t_q[63:32]};
  assign rem_sh  = {rem_q, lo_q[31]};
  assign geq     = rem_sh >= {1'b0, dd_q};
  assign sub_res = {sum_q[47], sum_q} - {{17{coeff_q[31]}}, coeff_q};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    acc_d       = acc_q;
    dn_d        = dn_q;
    neg_d       = neg_q;
    dd_d        = dd_q;
    t_d         = t_q;
    num_d       = num_q;
    rem_d       = rem_q;
    lo_d        = lo_q;
    quo_d       = quo_q;
    coeff_d     = coeff_q;
    res_kind_d  = res_kind_q;
    res_col_d   = res_col_q;
    res_val_d   = res_val_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_kind_d  = out_kind_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      fvlra_pkg::ST_IDLE: begin
        if (in_acc) begin
          cnt_d = '0;
          if (bad_idx || ((action_i == fvlra_pkg::ACT_BOUNDARY) &&
                          (boundary_kind_i == fvlra_pkg::BND_UNKNOWN))) begin
            sum_d      = '0;
            res_kind_d = fvlra_pkg::ENT_ERROR;
            res_col_d  = '0;
            res_val_d  = '0;
            state_d    = fvlra_pkg::ST_RES;
          end else if ((action_i == fvlra_pkg::ACT_INTERIOR) ||
                       (boundary_kind_i == fvlra_pkg::BND_FIXED)) begin
            state_d = fvlra_pkg::ST_MUL;
          end else if (last_link_i) begin
            state_d = fvlra_pkg::ST_DIAG;
          end
        end
      end

      fvlra_pkg::ST_MUL: begin
        cnt_d = cnt_q + 5'd1;
        case (cnt_q)
          5'd1: acc_d = prod_q;
          5'd2: begin
            neg_d = dot_sum[65];
            dn_d  = dot_sum[65] ? 64'(66'd0 - dot_sum) : dot_sum[63:0];
          end
          5'd3: acc_d = prod_q;
          5'd4: dd_d = acc_q[63:0] + prod_q[63:0];
          5'd5: t_d = prod_q[63:0];
          default: begin
            if (cnt_q == fvlra_pkg::MUL_LAST) begin
              num_d   = {u_sum, t_q[31:0]};
              state_d = fvlra_pkg::ST_CHK;
            end
          end
        endcase
      end

      fvlra_pkg::ST_CHK: begin
        cnt_d = '0;
        if (dd_q == 64'd0) begin
          coeff_d = fvlra_pkg::Q_MAX;
          state_d = fvlra_pkg::ST_APPLY;
        end else if (num_q[95:32] >= dd_q) begin
          // Quotient is at least 2^32, so it saturates either way.
          coeff_d = neg_q ? fvlra_pkg::Q_MIN : fvlra_pkg::Q_MAX;
          state_d = fvlra_pkg::ST_APPLY;
        end else begin
          rem_d   = num_q[95:32];
          lo_d    = num_q[31:0];
          quo_d   = '0;
          state_d = fvlra_pkg::ST_DIV;
        end
      end

      fvlra_pkg::ST_DIV: begin
        rem_d = geq ? 64'(rem_sh - {1'b0, dd_q}) : rem_sh[63:0];
        lo_d  = {lo_q[30:0], 1'b0};
        quo_d = {quo_q[30:0], geq};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == fvlra_pkg::DIV_LAST) begin
          state_d = fvlra_pkg::ST_QSAT;
        end
      end

      fvlra_pkg::ST_QSAT: begin
        coeff_d = fvlra_pkg::sat_mag(neg_q, {16'b0, quo_q});
        state_d = fvlra_pkg::ST_APPLY;
      end

      fvlra_pkg::ST_APPLY: begin
        if (sub_res[48] != sub_res[47]) begin
          sum_d = sub_res[48] ? fvlra_pkg::SUM_MIN : fvlra_pkg::SUM_MAX;
        end else begin
          sum_d = sub_res[47:0];
        end
        if (action_q == fvlra_pkg::ACT_BOUNDARY) begin
          state_d = fvlra_pkg::ST_RHS_MUL;
        end else begin
          res_kind_d = fvlra_pkg::ENT_OFFDIAG;
          res_col_d  = col_q;
          res_val_d  = coeff_q;
          state_d    = fvlra_pkg::ST_RES;
        end
      end

      fvlra_pkg::ST_RHS_MUL: begin
        state_d = fvlra_pkg::ST_RHS_SAT;
      end

      fvlra_pkg::ST_RHS_SAT: begin
        // Increment is -coeff * value, so it is negative when the signs agree.
        res_kind_d = fvlra_pkg::ENT_RHS;
        res_col_d  = '0;
        res_val_d  = fvlra_pkg::sat_mag(coeff_q[31] == bval_q[31], prod_q[63:16]);
        state_d    = fvlra_pkg::ST_RES;
      end

      fvlra_pkg::ST_RES: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = res_kind_q;
          out_row_d   = row_q;
          out_col_d   = res_col_q;
          out_val_d   = res_val_q;
          out_last_d  = !last_q;
          state_d     = last_q ? fvlra_pkg::ST_DIAG : fvlra_pkg::ST_IDLE;
        end
      end

      fvlra_pkg::ST_DIAG: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = fvlra_pkg::ENT_DIAG;
          out_row_d   = row_q;
          out_col_d   = row_q;
          out_val_d   = fvlra_pkg::sat_sum(sum_q);
          out_last_d  = 1'b1;
          sum_d       = '0;
          state_d     = fvlra_pkg::ST_IDLE;
        end
      end

      default: state_d = fvlra_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fvlra_pkg::ST_IDLE;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q <= action_i;
      row_q    <= row_index_i;
      col_q    <= neighbour_index_i;
      rx_q     <= dist_x_i;
      ry_q     <= dist_y_i;
      nx_q     <= norm_x_i;
      ny_q     <= norm_y_i;
      gamma_q  <= face_gamma_i;
      bval_q   <= boundary_value_i;
      last_q   <= last_link_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= mul_a * mul_b;
    acc_q      <= acc_d;
    dn_q       <= dn_d;
    neg_q      <= neg_d;
    dd_q       <= dd_d;
    t_q        <= t_d;
    num_q      <= num_d;
    rem_q      <= rem_d;
    lo_q       <= lo_d;
    quo_q      <= quo_d;
    coeff_q    <= coeff_d;
    res_kind_q <= res_kind_d;
    res_col_q  <= res_col_d;
    res_val_q  <= res_val_d;
    out_kind_q <= out_kind_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign entry_kind_o  = out_kind_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign out_value_o   = out_val_q;
  assign last_of_run_o = out_last_q;

  a_unknown_clears_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (action_i == fvlra_pkg::ACT_BOUNDARY) &&
     (boundary_kind_i == fvlra_pkg::BND_UNKNOWN)) |=> (sum_q == 48'd0))
    else $error("unrecognized boundary link did not clear the central sum");

  a_diag_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (entry_kind_o == fvlra_pkg::ENT_DIAG)) |->
      (last_of_run_o && (out_col_o == out_row_o)))
    else $error("diagonal beat must be last and sit on the row");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (entry_kind_o == fvlra_pkg::ENT_ERROR)) |->
      ((out_value_o == 32'd0) && (out_col_o == 16'd0)))
    else $error("error beat must carry zero value and column");

  a_diag_clears_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == fvlra_pkg::ST_DIAG) && out_free) |=> (sum_q == 48'd0))
    else $error("central sum not cleared after the diagonal entry");

endmodule
